// File: hw/rtl/rfgb_pkg.sv
// Package for the rangefinder ground-bootstrap machine.
// Request structs, status and register index codes, register reset values.
// No dependencies.
`timescale 1ns / 1ps

package rfgb_pkg;

  // Reading status codes; 5..7 are unknown and behave like an error.
  localparam logic [2:0] ST_VALID     = 3'd0;
  localparam logic [2:0] ST_TOO_CLOSE = 3'd1;
  localparam logic [2:0] ST_TOO_FAR   = 3'd2;
  localparam logic [2:0] ST_NOT_READY = 3'd3;
  localparam logic [2:0] ST_ERROR     = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_BOOT_DIST   = 3'd0;
  localparam logic [2:0] REG_BOOT_EXIT   = 3'd1;
  localparam logic [2:0] REG_AIR_CLEAR   = 3'd2;
  localparam logic [2:0] REG_LAND_ARM    = 3'd3;
  localparam logic [2:0] REG_LAND_NEAR   = 3'd4;
  localparam logic [2:0] REG_FLIGHT_TGT  = 3'd5;
  localparam logic [2:0] REG_LAND_TGT    = 3'd6;
  localparam logic [2:0] REG_MAX_AGE     = 3'd7;

  // Register reset values
  localparam logic [15:0] RST_BOOT_DIST  = 16'd20;
  localparam logic [15:0] RST_BOOT_EXIT  = 16'd60;
  localparam logic [15:0] RST_AIR_CLEAR  = 16'd300;
  localparam logic [15:0] RST_LAND_ARM   = 16'd150;
  localparam logic [15:0] RST_LAND_NEAR  = 16'd80;
  localparam logic [7:0]  RST_FLIGHT_TGT = 8'd3;
  localparam logic [7:0]  RST_LAND_TGT   = 8'd3;
  localparam logic [7:0]  RST_MAX_AGE    = 8'd10;

  // Age counter ceiling
  localparam logic [7:0] AGE_MAX = 8'd255;

  typedef struct packed {
    logic [2:0]  read_status;
    logic [15:0] range_mm;
  } rfgb_in_t;

  typedef struct packed {
    logic        publish;
    logic [15:0] out_mm;
    logic        ground_fix;
  } rfgb_out_t;

  typedef enum logic [2:0] {
    MODE_BOOT   = 3'b001,
    MODE_FLIGHT = 3'b010,
    MODE_LAND   = 3'b100
  } rfgb_mode_e;

endpackage

// File: hw/rtl/rangefinder_ground_bootstrap_fsm.sv
// Top level of the rangefinder ground-bootstrap machine.
// Input register, mode/counter update logic, result register, config registers.
// Depends on rfgb_pkg.
`timescale 1ns / 1ps

//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+------------------------
//  in        | input     | in_valid_i / in_stall_o   | in_req_i  (rfgb_in_t)
//  out       | output    | out_valid_o / out_stall_i | out_req_o (rfgb_out_t)
//  cfg       | input     | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained unless the output stalls. The request is
// captured in the input register, then the mode machine evaluates it and its
// result lands in the result register, with the state updated on the same edge.
// Reset (asynchronous, active low) puts the machine in bootstrap with all
// counters cleared and the registers at their defaults.
// A stall at the output holds the result; the input register keeps taking a
// request as long as the result register can drain or is empty.

module rangefinder_ground_bootstrap_fsm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  rfgb_pkg::rfgb_in_t in_req_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output rfgb_pkg::rfgb_out_t out_req_o,
  input  logic               out_stall_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import rfgb_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [15:0] boot_dist_q, boot_exit_q, air_clear_q, land_arm_q, land_near_q;
  logic [7:0]  flight_tgt_q, land_tgt_q, max_age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      boot_dist_q  <= RST_BOOT_DIST;
      boot_exit_q  <= RST_BOOT_EXIT;
      air_clear_q  <= RST_AIR_CLEAR;
      land_arm_q   <= RST_LAND_ARM;
      land_near_q  <= RST_LAND_NEAR;
      flight_tgt_q <= RST_FLIGHT_TGT;
      land_tgt_q   <= RST_LAND_TGT;
      max_age_q    <= RST_MAX_AGE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BOOT_DIST:  boot_dist_q  <= cfg_wdata_i;
        REG_BOOT_EXIT:  boot_exit_q  <= cfg_wdata_i;
        REG_AIR_CLEAR:  air_clear_q  <= cfg_wdata_i;
        REG_LAND_ARM:   land_arm_q   <= cfg_wdata_i;
        REG_LAND_NEAR:  land_near_q  <= cfg_wdata_i;
        REG_FLIGHT_TGT: flight_tgt_q <= cfg_wdata_i[7:0];
        REG_LAND_TGT:   land_tgt_q   <= cfg_wdata_i[7:0];
        REG_MAX_AGE:    max_age_q    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake: input register -> result register
  // ---------------------------------------------------------------------
  logic      in_valid_q;
  rfgb_in_t  in_q;
  logic      out_valid_q;
  rfgb_out_t out_q;
  logic      out_ready;   // result register can take a new result
  logic      advance;     // held request is evaluated and retired
  logic      in_take;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_req_i;
    end
  end

  // ---------------------------------------------------------------------
  // Mode machine state
  // ---------------------------------------------------------------------
  rfgb_mode_e mode_q, mode_d;
  logic [7:0] fc_q, fc_d;     // consecutive high readings in bootstrap
  logic [7:0] lc_q, lc_d;     // landing confirm count
  logic       acs_q, acs_d;   // airborne clear seen
  logic       armed_q, armed_d;
  logic [7:0] age_q, age_d;   // updates since last valid, saturating
  rfgb_out_t  res;

  logic [2:0]  st;
  logic [15:0] mm;
  logic        is_valid, is_close;
  logic [7:0]  fc_inc, lc_inc;
  logic        low_ev;
  logic        armed_f;

  always_comb begin
    st       = in_q.read_status;
    mm       = in_q.range_mm;
    is_valid = (st == ST_VALID);
    is_close = (st == ST_TOO_CLOSE);

    // Age moves first; low-evidence check sees the new value.
    if (is_valid) begin
      age_d = 8'd0;
    end else if (age_q != AGE_MAX) begin
      age_d = age_q + 8'd1;
    end else begin
      age_d = age_q;
    end

    fc_inc  = (fc_q < flight_tgt_q) ? fc_q + 8'd1 : fc_q;
    lc_inc  = (lc_q < land_tgt_q) ? lc_q + 8'd1 : lc_q;
    low_ev  = acs_q && armed_q && (age_d <= max_age_q);
    armed_f = armed_q;

    mode_d  = mode_q;
    fc_d    = fc_q;
    lc_d    = lc_q;
    acs_d   = acs_q;
    armed_d = armed_q;
    res     = '0;

    case (mode_q)
      MODE_BOOT: begin
        if (is_close) begin
          fc_d = 8'd0;
          res  = '{publish: 1'b1, out_mm: boot_dist_q, ground_fix: 1'b1};
        end else if (is_valid) begin
          if (mm < boot_exit_q) begin
            fc_d = 8'd0;
            res  = '{publish: 1'b1, out_mm: boot_dist_q, ground_fix: 1'b1};
          end else if (fc_inc >= flight_tgt_q) begin
            // enough high readings: take off
            mode_d  = MODE_FLIGHT;
            fc_d    = 8'd0;
            acs_d   = (mm >= air_clear_q);
            armed_d = 1'b0;
            res     = '{publish: 1'b1, out_mm: mm, ground_fix: 1'b0};
          end else begin
            fc_d = fc_inc;
            res  = '{publish: 1'b1, out_mm: boot_dist_q, ground_fix: 1'b1};
          end
        end else if (st != ST_NOT_READY) begin
          fc_d = 8'd0;
        end
      end

      MODE_FLIGHT: begin
        if (is_valid) begin
          if (mm >= air_clear_q) begin
            acs_d   = 1'b1;
            armed_f = 1'b0;
          end else if (acs_q) begin
            armed_f = (mm <= land_arm_q);
          end
          armed_d = armed_f;
          if (armed_f && (mm <= land_near_q)) begin
            mode_d = MODE_LAND;
            lc_d   = 8'd1;
          end
          res = '{publish: 1'b1, out_mm: mm, ground_fix: 1'b0};
        end else if (is_close && low_ev) begin
          mode_d = MODE_LAND;
          lc_d   = 8'd1;
        end
      end

      default: begin
        // landing confirm
        if (is_valid) begin
          if (mm >= air_clear_q) begin
            mode_d  = MODE_FLIGHT;
            lc_d    = 8'd0;
            acs_d   = 1'b1;
            armed_d = 1'b0;
            res     = '{publish: 1'b1, out_mm: mm, ground_fix: 1'b0};
          end else if (mm > land_near_q) begin
            mode_d  = MODE_FLIGHT;
            lc_d    = 8'd0;
            armed_d = (mm <= land_arm_q);
            res     = '{publish: 1'b1, out_mm: mm, ground_fix: 1'b0};
          end else if (lc_inc >= land_tgt_q) begin
            // landed: back to bootstrap, all evidence cleared
            mode_d  = MODE_BOOT;
            fc_d    = 8'd0;
            lc_d    = 8'd0;
            acs_d   = 1'b0;
            armed_d = 1'b0;
            age_d   = 8'd0;
            res     = '{publish: 1'b1, out_mm: boot_dist_q, ground_fix: 1'b1};
          end else begin
            lc_d = lc_inc;
            res  = '{publish: 1'b1, out_mm: mm, ground_fix: 1'b0};
          end
        end else if (is_close) begin
          if (!low_ev) begin
            mode_d  = MODE_FLIGHT;
            lc_d    = 8'd0;
            armed_d = 1'b0;
          end else if (lc_inc >= land_tgt_q) begin
            mode_d  = MODE_BOOT;
            fc_d    = 8'd0;
            lc_d    = 8'd0;
            acs_d   = 1'b0;
            armed_d = 1'b0;
            age_d   = 8'd0;
            res     = '{publish: 1'b1, out_mm: boot_dist_q, ground_fix: 1'b1};
          end else begin
            lc_d = lc_inc;
          end
        end else if (age_d > max_age_q) begin
          // stale data: fall back to flight
          mode_d  = MODE_FLIGHT;
          lc_d    = 8'd0;
          armed_d = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BOOT;
      fc_q    <= 8'd0;
      lc_q    <= 8'd0;
      acs_q   <= 1'b0;
      armed_q <= 1'b0;
      age_q   <= 8'd0;
    end else if (advance) begin
      mode_q  <= mode_d;
      fc_q    <= fc_d;
      lc_q    <= lc_d;
      acs_q   <= acs_d;
      armed_q <= armed_d;
      age_q   <= age_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_boot_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_BOOT |-> !acs_q && !armed_q && lc_q == 8'd0)
    else $error("bootstrap mode with landing evidence left over");

  a_land_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_LAND |-> lc_q != 8'd0 && fc_q == 8'd0)
    else $error("landing confirm with bad counters");

  a_armed_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> acs_q)
    else $error("landing armed without airborne clear");

  a_boot_pub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.ground_fix |-> out_q.publish)
    else $error("bootstrap flag on an unpublished result");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(mode_q) && $stable(age_q))
    else $error("state moved without a retired request");

endmodule
